// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Each macro expects clk and arst_n to exist in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VFCAO_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define VFCAO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/vfcao_pkg.sv =====
// Package for the voxel face cull / ambient occlusion block.
// Types, widths, corner lookup tables. No dependencies.
`timescale 1ns / 1ps

package vfcao_pkg;

	localparam int CHUNK_HEIGHT = 256;
	localparam int CHUNK_SIDE   = 16;

	localparam int NUM_FACES   = 6;
	localparam int NUM_CORNERS = 4;

	localparam int XZ_W     = 4;
	localparam int Y_W      = 8;
	localparam int MASK_W   = 27;
	localparam int TILES_W  = 48;
	localparam int LEVELS_W = 24;
	localparam int FACE_W   = 3;
	localparam int NIB_W    = 4;
	localparam int LIGHT_W  = 5;
	localparam int SHADE_W  = 8;
	localparam int BIT_W    = 5;

	localparam int S_TDATA_W = 144;
	localparam int M_TDATA_W = 72;

	// saturation limits for position
	localparam int XZ_MAX = CHUNK_SIDE - 1;
	localparam int Y_MAX  = (CHUNK_HEIGHT - 1 > 255) ? 255 : CHUNK_HEIGHT - 1;

	// exact floor(v/3) for v < 2048: (v * 683) >> 11
	localparam int SHADE_MUL = 17;
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int V_W        = 11;
	localparam int P_W        = 21;
	localparam int Q_W        = P_W - DIV3_SHIFT;
	localparam int SHADE_MAX  = 255;

	// mask bit of the facing neighbor, order +x -x +y -y +z -z
	localparam logic [BIT_W-1:0] NBR_BIT [NUM_FACES] =
		'{5'd22, 5'd4, 5'd16, 5'd10, 5'd14, 5'd12};

	// for each face and corner: the corner itself, and both of its edge neighbors
	localparam logic [BIT_W-1:0] CORNER_BIT [NUM_FACES][NUM_CORNERS] = '{
		'{5'd18, 5'd24, 5'd26, 5'd20},
		'{5'd8,  5'd6,  5'd0,  5'd2 },
		'{5'd26, 5'd24, 5'd6,  5'd8 },
		'{5'd0,  5'd18, 5'd20, 5'd2 },
		'{5'd2,  5'd20, 5'd26, 5'd8 },
		'{5'd24, 5'd18, 5'd0,  5'd6 }
	};
	localparam logic [BIT_W-1:0] SIDE1_BIT [NUM_FACES][NUM_CORNERS] = '{
		'{5'd21, 5'd21, 5'd23, 5'd23},
		'{5'd5,  5'd3,  5'd3,  5'd5 },
		'{5'd25, 5'd25, 5'd7,  5'd7 },
		'{5'd1,  5'd19, 5'd19, 5'd1 },
		'{5'd11, 5'd11, 5'd17, 5'd17},
		'{5'd15, 5'd9,  5'd9,  5'd15}
	};
	localparam logic [BIT_W-1:0] SIDE2_BIT [NUM_FACES][NUM_CORNERS] = '{
		'{5'd19, 5'd25, 5'd25, 5'd19},
		'{5'd7,  5'd7,  5'd1,  5'd1 },
		'{5'd17, 5'd15, 5'd15, 5'd17},
		'{5'd9,  5'd9,  5'd11, 5'd11},
		'{5'd5,  5'd23, 5'd23, 5'd5 },
		'{5'd21, 5'd21, 5'd3,  5'd3 }
	};

	// one decoded voxel, as handed from intake to the emitter
	typedef struct packed {
		logic [XZ_W-1:0]      x;
		logic [Y_W-1:0]       y;
		logic [XZ_W-1:0]      z;
		logic [MASK_W-1:0]    mask;
		logic [TILES_W-1:0]   tiles;
		logic [LEVELS_W-1:0]  sun;
		logic [LEVELS_W-1:0]  torch;
		logic [Y_W-1:0]       top;
		logic [NUM_FACES-1:0] open;
	} item_t;

	// one face result
	typedef struct packed {
		logic [XZ_W-1:0]                      x;
		logic [Y_W-1:0]                       y;
		logic [XZ_W-1:0]                      z;
		logic [FACE_W-1:0]                    face;
		logic [NIB_W-1:0]                     tile_u;
		logic [NIB_W-1:0]                     tile_v;
		logic [NUM_CORNERS-1:0][SHADE_W-1:0]  shade;
		logic [Y_W-1:0]                       top;
		logic                                 last;
	} result_t;

endpackage

// ===== rtl/core/vfcao_intake.sv =====
// Intake: unpacks the input beat, saturates position, tracks chunk top height.
// Depends on vfcao_pkg.
`timescale 1ns / 1ps

module vfcao_intake (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           chunk_start,
	input  logic [vfcao_pkg::S_TDATA_W-1:0] tdata,
	output vfcao_pkg::item_t               item
);

	logic [vfcao_pkg::Y_W-1:0]  top_q;
	logic [vfcao_pkg::Y_W-1:0]  top_base;
	logic [vfcao_pkg::Y_W-1:0]  top_next;
	logic [vfcao_pkg::XZ_W-1:0] raw_x;
	logic [vfcao_pkg::Y_W-1:0]  raw_y;
	logic [vfcao_pkg::XZ_W-1:0] raw_z;
	logic                       present;
	logic [vfcao_pkg::MASK_W-1:0] mask;

	assign raw_x   = tdata[3:0];
	assign raw_y   = tdata[11:4];
	assign raw_z   = tdata[15:12];
	assign present = tdata[16];
	assign mask    = tdata[43:17];

	always_comb begin
		item.x = (int'(raw_x) > vfcao_pkg::XZ_MAX) ?
			vfcao_pkg::XZ_W'(vfcao_pkg::XZ_MAX) : raw_x;
		item.z = (int'(raw_z) > vfcao_pkg::XZ_MAX) ?
			vfcao_pkg::XZ_W'(vfcao_pkg::XZ_MAX) : raw_z;
		item.y = (int'(raw_y) > vfcao_pkg::Y_MAX) ?
			vfcao_pkg::Y_W'(vfcao_pkg::Y_MAX) : raw_y;
		item.mask  = mask;
		item.tiles = tdata[91:44];
		item.sun   = tdata[115:92];
		item.torch = tdata[139:116];

		// chunk_start clears first, even for an absent voxel
		top_base = chunk_start ? '0 : top_q;
		top_next = (present && item.y > top_base) ? item.y : top_base;
		item.top = top_next;

		for (int f = 0; f < vfcao_pkg::NUM_FACES; f++) begin
			item.open[f] = present && !mask[vfcao_pkg::NBR_BIT[f]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (accept) begin
			top_q <= top_next;
		end
	end

endmodule

// ===== rtl/core/vfcao_shade.sv =====
// Corner occlusion and shade for the four corners of one face.
// Combinational; depends on vfcao_pkg corner tables.
`timescale 1ns / 1ps

module vfcao_shade (
	input  logic [vfcao_pkg::MASK_W-1:0]  mask,
	input  logic [vfcao_pkg::FACE_W-1:0]  face,
	input  logic [vfcao_pkg::LIGHT_W-1:0] light,
	output logic [vfcao_pkg::NUM_CORNERS-1:0][vfcao_pkg::SHADE_W-1:0] shade
);

	logic [vfcao_pkg::NUM_CORNERS-1:0]                     o1, o2, oc;
	logic [vfcao_pkg::NUM_CORNERS-1:0][1:0]                occ;
	logic [vfcao_pkg::NUM_CORNERS-1:0][1:0]                lit;
	logic [vfcao_pkg::NUM_CORNERS-1:0][vfcao_pkg::V_W-1:0] v;
	logic [vfcao_pkg::NUM_CORNERS-1:0][vfcao_pkg::P_W-1:0] p;
	logic [vfcao_pkg::NUM_CORNERS-1:0][vfcao_pkg::Q_W-1:0] q;

	always_comb begin
		for (int k = 0; k < vfcao_pkg::NUM_CORNERS; k++) begin
			o1[k] = mask[vfcao_pkg::SIDE1_BIT[face][k]];
			o2[k] = mask[vfcao_pkg::SIDE2_BIT[face][k]];
			oc[k] = mask[vfcao_pkg::CORNER_BIT[face][k]];
			// corner counts only when both edges are open
			occ[k] = 2'(o1[k]) + 2'(o2[k]) + 2'(!o1[k] && !o2[k] && oc[k]);
			lit[k] = 2'd3 - occ[k];
			v[k] = vfcao_pkg::V_W'(lit[k]) * vfcao_pkg::V_W'(light)
				* vfcao_pkg::V_W'(vfcao_pkg::SHADE_MUL);
			p[k] = vfcao_pkg::P_W'(v[k]) * vfcao_pkg::P_W'(vfcao_pkg::DIV3_MUL);
			q[k] = p[k][vfcao_pkg::P_W-1:vfcao_pkg::DIV3_SHIFT];
			shade[k] = (int'(q[k]) > vfcao_pkg::SHADE_MAX) ?
				vfcao_pkg::SHADE_W'(vfcao_pkg::SHADE_MAX) : q[k][vfcao_pkg::SHADE_W-1:0];
		end
	end

endmodule

// ===== rtl/core/vfcao_emit.sv =====
// Emitter: holds one voxel, walks its open faces one per unstalled
// cycle into the result register. Depends on vfcao_pkg and vfcao_shade.
`timescale 1ns / 1ps

module vfcao_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  vfcao_pkg::item_t     item,
	output logic                 take_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	output vfcao_pkg::result_t   result
);

	vfcao_pkg::item_t                 item_s1;
	logic [vfcao_pkg::NUM_FACES-1:0]  pend_s1;
	logic [vfcao_pkg::NUM_FACES-1:0]  sel_hot;
	logic [vfcao_pkg::NUM_FACES-1:0]  pend_rest;
	logic [vfcao_pkg::FACE_W-1:0]     sel_face;
	logic                             found;
	logic                             load_out;
	logic                             issue;
	logic [vfcao_pkg::NIB_W-1:0]      sun_nib;
	logic [vfcao_pkg::NIB_W-1:0]      torch_nib;
	logic [vfcao_pkg::LIGHT_W-1:0]    light;
	logic [vfcao_pkg::NUM_CORNERS-1:0][vfcao_pkg::SHADE_W-1:0] shade;
	logic                             out_valid_q;
	vfcao_pkg::result_t               result_q;

	// lowest pending face goes next
	always_comb begin
		sel_face = '0;
		found    = 1'b0;
		for (int f = 0; f < vfcao_pkg::NUM_FACES; f++) begin
			if (pend_s1[f] && !found) begin
				sel_face = vfcao_pkg::FACE_W'(f);
				found    = 1'b1;
			end
		end
	end

	assign sel_hot    = vfcao_pkg::NUM_FACES'(1) << sel_face;
	assign pend_rest  = pend_s1 & ~sel_hot;
	assign load_out   = !out_valid_q || out_ready;
	assign issue      = (pend_s1 != '0) && load_out;
	assign take_ready = (pend_s1 == '0) || (issue && (pend_rest == '0));

	assign sun_nib   = item_s1.sun[sel_face*vfcao_pkg::NIB_W +: vfcao_pkg::NIB_W];
	assign torch_nib = item_s1.torch[sel_face*vfcao_pkg::NIB_W +: vfcao_pkg::NIB_W];
	assign light     = vfcao_pkg::LIGHT_W'(sun_nib) + vfcao_pkg::LIGHT_W'(torch_nib);

	vfcao_shade u_shade (
		.mask  (item_s1.mask),
		.face  (sel_face),
		.light (light),
		.shade (shade)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_s1 <= item.open;
			end else if (issue) begin
				pend_s1 <= pend_rest;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (issue) begin
			result_q.x      <= item_s1.x;
			result_q.y      <= item_s1.y;
			result_q.z      <= item_s1.z;
			result_q.face   <= sel_face;
			result_q.tile_u <= item_s1.tiles[sel_face*8 +: vfcao_pkg::NIB_W];
			result_q.tile_v <= item_s1.tiles[sel_face*8 + vfcao_pkg::NIB_W +: vfcao_pkg::NIB_W];
			result_q.shade  <= shade;
			result_q.top    <= item_s1.top;
			result_q.last   <= (pend_rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ===== rtl/core/voxel_face_cull_ambient_occlusion_top.sv =====
// Top level of the voxel face cull / ambient occlusion block.
// Depends on vfcao_pkg, vfcao_intake, vfcao_emit (and vfcao_shade below it).
`timescale 1ns / 1ps

// Usage
//  Input stream s_axis: one beat per voxel. tuser carries chunk_start, which
//  zeroes the running top height before this voxel counts. tdata carries the
//  position, present flag, 3x3x3 solidity mask, six atlas tiles, and per-face
//  sun and torch levels.
//  Output stream m_axis: one beat per open face of a present voxel, faces in
//  order +x, -x, +y, -y, +z, -z; tlast marks the voxel's final face. A voxel
//  with no open face (absent or fully enclosed) makes no beat; an enclosed
//  one still updates the top height, and chunk_start still clears it.
//  A voxel is held in the emitter; each face is then registered as a result.
//  Throughput: the emitter puts out one face per cycle from its holding
//  register unless m_axis_tready stalls it. The next voxel is taken in the
//  cycle its predecessor's final face moves into the result register.
//  Stall: with m_axis_tready low the result beat holds; the held voxel waits
//  and s_axis_tready drops once the held voxel still has faces to send.
//  Reset (arst_n low, asynchronous): no beat pending, top height zero.

module voxel_face_cull_ambient_occlusion_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pos_x[3:0] pos_y[11:4] pos_z[15:12] present[16] solid_mask[43:17]
	// face_tiles[91:44] sun_levels[115:92] torch_levels[139:116], zero pad
	input  logic [vfcao_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// chunk_start[0]
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_x[3:0] out_y[11:4] out_z[15:12] face_dir[18:16] tile_u[22:19]
	// tile_v[26:23] shade_first[34:27] shade_second[42:35]
	// shade_third[50:43] shade_fourth[58:51] top_height[66:59], zero pad
	output logic [vfcao_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast
);

	logic               accept;
	logic               take_ready;
	vfcao_pkg::item_t   item;
	vfcao_pkg::result_t result;

	// beat taken whenever the emitter can hold it
	assign s_axis_tready = take_ready;
	assign accept        = s_axis_tvalid && take_ready;

	vfcao_intake u_intake (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.chunk_start (s_axis_tuser),
		.tdata       (s_axis_tdata),
		.item        (item)
	);

	vfcao_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.take_ready (take_ready),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.result     (result)
	);

	// pack the result beat, highest field first, x in the lowest bits
	assign m_axis_tdata = {
		5'b0,
		result.top,
		result.shade[3],
		result.shade[2],
		result.shade[1],
		result.shade[0],
		result.tile_v,
		result.tile_u,
		result.face,
		result.z,
		result.y,
		result.x
	};
	assign m_axis_tlast = result.last;

endmodule

// ===== rtl/core/vfcao_checker.sv =====
// Port-level checker for the voxel face cull block, bound to the top level.
// Depends on assert_macros.svh and vfcao_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vfcao_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [vfcao_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast
);

	logic                            out_mid;
	logic                            out_stall;
	logic [vfcao_pkg::M_TDATA_W:0]   out_beat;
	logic [vfcao_pkg::FACE_W-1:0]    out_face;
	logic [vfcao_pkg::Y_W+15:0]      out_voxel;

	// a face went out and more of the same voxel follow
	assign out_mid   = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_beat  = {m_axis_tlast, m_axis_tdata};
	assign out_face  = m_axis_tdata[18:16];
	// top height and position
	assign out_voxel = {m_axis_tdata[66:59], m_axis_tdata[15:0]};

	// stalled result beat holds
	`VFCAO_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_beat))

	// faces of one voxel go out back to back
	`VFCAO_ASSERT_NEXT(a_face_gapless, out_mid, m_axis_tvalid)

	// face order strictly rises within a voxel
	`VFCAO_ASSERT_NEXT(a_face_order, out_mid, out_face > $past(out_face))

	// position and top height stay fixed within a voxel
	`VFCAO_ASSERT_NEXT(a_same_voxel, out_mid, out_voxel == $past(out_voxel))

endmodule

bind voxel_face_cull_ambient_occlusion_top vfcao_checker u_checker (.*);

// ===== verif/vfcao_face_checker.sv =====
// Scoreboard for the voxel face cull / ambient occlusion block: predicts the face beats of
// every accepted voxel and compares them with the m_axis beats. Depends on vfcao_pkg.
`timescale 1ns / 1ps

module vfcao_face_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [vfcao_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [vfcao_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast,
	output int                              faces_pending,
	output int                              mismatches
);

	typedef enum logic [vfcao_pkg::FACE_W-1:0] {
		FACE_POS_X, FACE_NEG_X, FACE_POS_Y, FACE_NEG_Y, FACE_POS_Z, FACE_NEG_Z
	} face_t;

	vfcao_pkg::result_t        face_q[$];
	logic [vfcao_pkg::Y_W-1:0] peak_y;

	function automatic bit solid_at(input logic [vfcao_pkg::MASK_W-1:0] mask, input int dx,
			input int dy, input int dz);
		return mask[(dx + 1) * 9 + (dy + 1) * 3 + (dz + 1)];
	endfunction

	// corner k of a face in vertex order, one bit per axis {x,y,z}: 1 is +1, 0 is -1
	function automatic logic [2:0] corner_signs(input int face, input int k);
		logic [11:0] quad;
		case (face_t'(face))
			FACE_POS_X: quad = 12'b101_111_110_100;
			FACE_NEG_X: quad = 12'b001_000_010_011;
			FACE_POS_Y: quad = 12'b011_010_110_111;
			FACE_NEG_Y: quad = 12'b001_101_100_000;
			FACE_POS_Z: quad = 12'b011_111_101_001;
			default:    quad = 12'b010_000_100_110;
		endcase
		return quad[3 * k +: 3];
	endfunction

	task automatic predict_voxel_faces(input logic [vfcao_pkg::S_TDATA_W-1:0] d,
			input logic chunk);
		logic [vfcao_pkg::MASK_W-1:0]   mask;
		logic [vfcao_pkg::TILES_W-1:0]  tiles;
		logic [vfcao_pkg::LEVELS_W-1:0] sun;
		logic [vfcao_pkg::LEVELS_W-1:0] torch;
		logic [2:0]                     signs;
		int                             axis;
		int                             sgn;
		int                             light;
		int                             occ;
		int                             q;
		bit                             o1;
		bit                             o2;
		bit                             have_held;
		int                             c[3];
		int                             s1[3];
		int                             s2[3];
		vfcao_pkg::result_t             want;
		vfcao_pkg::result_t             held;
		mask      = d[43:17];
		tiles     = d[91:44];
		sun       = d[115:92];
		torch     = d[139:116];
		have_held = 1'b0;
		held      = '0;
		if (chunk)
			peak_y = '0;
		if (d[16]) begin
			if (d[11:4] > peak_y)
				peak_y = d[11:4];
			for (int f = 0; f < vfcao_pkg::NUM_FACES; f++) begin
				axis = f / 2;
				sgn  = (f % 2) ? -1 : 1;
				if (!solid_at(mask, (axis == 0) ? sgn : 0, (axis == 1) ? sgn : 0,
						(axis == 2) ? sgn : 0)) begin
					want        = '0;
					want.x      = d[3:0];
					want.y      = d[11:4];
					want.z      = d[15:12];
					want.face   = vfcao_pkg::FACE_W'(f);
					want.tile_u = tiles[8 * f +: 4];
					want.tile_v = tiles[8 * f + 4 +: 4];
					want.top    = peak_y;
					light       = int'(sun[4 * f +: 4]) + int'(torch[4 * f +: 4]);
					for (int k = 0; k < vfcao_pkg::NUM_CORNERS; k++) begin
						signs = corner_signs(f, k);
						c[0]  = signs[2] ? 1 : -1;
						c[1]  = signs[1] ? 1 : -1;
						c[2]  = signs[0] ? 1 : -1;
						// edge neighbors: drop one of the two in-plane axes each
						for (int i = 0; i < 3; i++) begin
							s1[i] = (i == (axis + 1) % 3) ? 0 : c[i];
							s2[i] = (i == (axis + 2) % 3) ? 0 : c[i];
						end
						o1  = solid_at(mask, s1[0], s1[1], s1[2]);
						o2  = solid_at(mask, s2[0], s2[1], s2[2]);
						occ = int'(o1) + int'(o2);
						if (!o1 && !o2 && solid_at(mask, c[0], c[1], c[2]))
							occ = 1;
						q = ((3 - occ) * light * 17) / 3;
						want.shade[k] = (q > vfcao_pkg::SHADE_MAX) ?
							vfcao_pkg::SHADE_W'(vfcao_pkg::SHADE_MAX) :
							vfcao_pkg::SHADE_W'(q);
					end
					if (have_held)
						face_q.push_back(held);
					held      = want;
					have_held = 1'b1;
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				face_q.push_back(held);
			end
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_face_beat();
		vfcao_pkg::result_t want;
		if (face_q.size() == 0) begin
			$error("face beat with no voxel pending: tdata %h", m_axis_tdata);
			mismatches++;
		end else begin
			want = face_q.pop_front();
			compare_field("out_x",        32'(want.x),        32'(m_axis_tdata[3:0]));
			compare_field("out_y",        32'(want.y),        32'(m_axis_tdata[11:4]));
			compare_field("out_z",        32'(want.z),        32'(m_axis_tdata[15:12]));
			compare_field("face_dir",     32'(want.face),     32'(m_axis_tdata[18:16]));
			compare_field("tile_u",       32'(want.tile_u),   32'(m_axis_tdata[22:19]));
			compare_field("tile_v",       32'(want.tile_v),   32'(m_axis_tdata[26:23]));
			compare_field("shade_first",  32'(want.shade[0]), 32'(m_axis_tdata[34:27]));
			compare_field("shade_second", 32'(want.shade[1]), 32'(m_axis_tdata[42:35]));
			compare_field("shade_third",  32'(want.shade[2]), 32'(m_axis_tdata[50:43]));
			compare_field("shade_fourth", 32'(want.shade[3]), 32'(m_axis_tdata[58:51]));
			compare_field("top_height",   32'(want.top),      32'(m_axis_tdata[66:59]));
			compare_field("last",         32'(want.last),     32'(m_axis_tlast));
		end
	endtask

	// a voxel's faces come out only after it is taken, so pop before push
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_y     = '0;
			mismatches = 0;
			face_q.delete();
			faces_pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_face_beat();
			if (s_axis_tvalid && s_axis_tready)
				predict_voxel_faces(s_axis_tdata, s_axis_tuser);
			faces_pending <= face_q.size();
		end
	end

endmodule

// ===== verif/voxel_face_cull_ambient_occlusion_top_tb.sv =====
// Testbench top for voxel_face_cull_ambient_occlusion_top: drives voxel beats and back
// pressure, gives the verdict. Depends on vfcao_pkg and vfcao_face_checker.
`timescale 1ns / 1ps

module voxel_face_cull_ambient_occlusion_top_tb;

	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int ITEMS_PER_PHASE = 137;

	// the six face neighbors, every 3D corner, and the edges off the y axis
	localparam logic [vfcao_pkg::MASK_W-1:0] FACE_NBRS = 27'h0415410;
	localparam logic [vfcao_pkg::MASK_W-1:0] CORNERS   = 27'h5140145;
	localparam logic [vfcao_pkg::MASK_W-1:0] Y_EDGES   = 27'h20A8A82;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [vfcao_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic                            s_axis_tuser  = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [vfcao_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tlast;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles  = 0;
	int faces_pending;
	int mismatches;

	always #5 clk = ~clk;

	voxel_face_cull_ambient_occlusion_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	vfcao_face_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.faces_pending (faces_pending),
		.mismatches    (mismatches)
	);

	// random back pressure on the face stream
	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watchdog: too long without a beat on either side means a hang
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles < STALL_LIMIT) begin
			stall_cycles <= stall_cycles + 1;
		end else begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// one voxel beat, with a random gap ahead of it; returns at the accepting edge
	task automatic send_voxel(input logic chunk, input logic [vfcao_pkg::XZ_W-1:0] x,
			input logic [vfcao_pkg::Y_W-1:0] y, input logic [vfcao_pkg::XZ_W-1:0] z,
			input logic present, input logic [vfcao_pkg::MASK_W-1:0] mask,
			input logic [vfcao_pkg::TILES_W-1:0] tiles,
			input logic [vfcao_pkg::LEVELS_W-1:0] sun,
			input logic [vfcao_pkg::LEVELS_W-1:0] torch);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= chunk;
		s_axis_tdata  <= {4'b0, torch, sun, tiles, mask, present, z, y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// hold off the sender until every predicted face has come out
	task automatic drain_faces();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (faces_pending != 0);
	endtask

	initial begin
		logic                           chunk;
		logic                           present;
		logic [vfcao_pkg::XZ_W-1:0]     px;
		logic [vfcao_pkg::Y_W-1:0]      py;
		logic [vfcao_pkg::XZ_W-1:0]     pz;
		logic [vfcao_pkg::MASK_W-1:0]   mask;
		logic [vfcao_pkg::TILES_W-1:0]  tiles;
		logic [vfcao_pkg::LEVELS_W-1:0] sun;
		logic [vfcao_pkg::LEVELS_W-1:0] torch;
		int                             stride;
		int                             nbr;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all faces open at full light, every shade saturates
		send_voxel(1'b1, 4'd0, 8'd0, 4'd0, 1'b1, '0, '1, '1, '1);
		// absent voxel opening a chunk: no beat, height cleared
		send_voxel(1'b1, 4'd5, 8'd9, 4'd5, 1'b0, 27'h1234567, '1, '1, '1);
		// fully enclosed voxel: no beat, but its height still counts
		send_voxel(1'b0, 4'd7, 8'd200, 4'd7, 1'b1, '1, 48'h0123456789AB, '1, '1);
		send_voxel(1'b0, 4'd15, 8'd10, 4'd15, 1'b1, '0, 48'h0123456789AB, 24'h123456,
			24'h654321);
		// extreme position, no light at all
		send_voxel(1'b0, 4'd15, 8'd255, 4'd15, 1'b1, '0, 48'hFEDCBA987654, '0, '0);
		// absent without chunk start leaves the height alone, with chunk start clears it
		send_voxel(1'b0, 4'd1, 8'd3, 4'd2, 1'b0, '0, '0, '0, '0);
		send_voxel(1'b1, 4'd2, 8'd4, 4'd3, 1'b0, '0, '0, '0, '0);
		send_voxel(1'b0, 4'd3, 8'd7, 4'd4, 1'b1, '0, 48'h5A5A5A5A5A5A, 24'h111111, 24'h0);
		// every side and corner solid: occlusion two on all corners
		send_voxel(1'b0, 4'd4, 8'd8, 4'd9, 1'b1, ~FACE_NBRS, 48'hA5A5A5A5A5A5, 24'h111111,
			24'h0);
		// corners only, both sides open: occlusion one
		send_voxel(1'b0, 4'd9, 8'd100, 4'd6, 1'b1, CORNERS, 48'h13579BDF0246, 24'hFEDCBA,
			24'h012345);
		// one side per corner solid (both on the y faces), corners also solid
		send_voxel(1'b0, 4'd10, 8'd50, 4'd11, 1'b1, CORNERS | Y_EDGES, 48'h0F0F0F0F0F0F,
			24'h89ABCD, 24'h765432);
		send_voxel(1'b0, 4'd11, 8'd51, 4'd12, 1'b1, Y_EDGES, 48'hF0F0F0F0F0F0, 24'h777777,
			24'h888888);
		// each face alone open, so each is both the only and the last face
		for (int f = 0; f < vfcao_pkg::NUM_FACES; f++) begin
			stride = (f / 2 == 0) ? 9 : ((f / 2 == 1) ? 3 : 1);
			nbr    = (f % 2) ? 13 - stride : 13 + stride;
			mask   = (vfcao_pkg::MASK_W'($urandom) & ~FACE_NBRS) |
				(FACE_NBRS & ~(vfcao_pkg::MASK_W'(1) << nbr));
			px     = vfcao_pkg::XZ_W'($urandom_range(0, 15));
			py     = vfcao_pkg::Y_W'($urandom_range(0, 255));
			pz     = vfcao_pkg::XZ_W'($urandom_range(0, 15));
			tiles  = vfcao_pkg::TILES_W'({$urandom, $urandom});
			sun    = vfcao_pkg::LEVELS_W'($urandom);
			torch  = vfcao_pkg::LEVELS_W'($urandom);
			send_voxel(1'b0, px, py, pz, 1'b1, mask, tiles, sun, torch);
		end
		// enclosed voxel right after a chunk start, then one with nothing set
		send_voxel(1'b1, 4'd6, 8'd1, 4'd6, 1'b1, '1, '0, '0, '0);
		send_voxel(1'b0, 4'd0, 8'd0, 4'd0, 1'b1, '0, '0, '0, '0);
		drain_faces();

		// random phases with changing idle mix, drained in between
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				chunk   = ($urandom_range(0, 99) < 4);
				present = ($urandom_range(0, 99) < 88);
				mask    = vfcao_pkg::MASK_W'($urandom);
				// vary the density so every occlusion count shows up
				case ($urandom_range(0, 3))
					0: mask = mask | vfcao_pkg::MASK_W'($urandom);
					1: mask = mask & vfcao_pkg::MASK_W'($urandom);
					default: ;
				endcase
				if ($urandom_range(0, 19) == 0)
					mask = mask | FACE_NBRS;
				tiles = vfcao_pkg::TILES_W'({$urandom, $urandom});
				sun   = vfcao_pkg::LEVELS_W'($urandom);
				torch = vfcao_pkg::LEVELS_W'($urandom);
				if ($urandom_range(0, 9) == 0) begin
					sun   = '1;
					torch = '1;
				end
				px = vfcao_pkg::XZ_W'($urandom_range(0, 15));
				py = vfcao_pkg::Y_W'($urandom_range(0, 255));
				pz = vfcao_pkg::XZ_W'($urandom_range(0, 15));
				send_voxel(chunk, px, py, pz, present, mask, tiles, sun, torch);
			end
			drain_faces();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
